// ===== src/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg: shared types for the multiply-with-flags block
// command codes, transaction payloads, flag bit positions
// ----------------------------------------------------------------------------
package imf_pkg;

    typedef enum logic [1:0] {
        CMD_MUL_BYTE  = 2'd0,
        CMD_MUL_WORD  = 2'd1,
        CMD_IMUL_BYTE = 2'd2,
        CMD_IMUL_WORD = 2'd3
    } cmd_t;

    // flag word bit positions
    localparam int unsigned FLAG_CF = 0;
    localparam int unsigned FLAG_PF = 2;
    localparam int unsigned FLAG_AF = 4;
    localparam int unsigned FLAG_ZF = 6;
    localparam int unsigned FLAG_SF = 7;
    localparam int unsigned FLAG_OF = 11;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] acc_value;
        logic [15:0] operand_value;
        logic [15:0] flags_in;
    } op_item_t;

    typedef struct packed {
        logic [15:0] ax_out;
        logic [15:0] dx_out;
        logic        dx_write;
        logic [15:0] flags_out;
    } res_item_t;

    // registered product stage, handed from the multiplier to the flag unit
    typedef struct packed {
        logic        word;
        logic        sgn;
        logic [31:0] product;
        logic [15:0] flags_in;
    } prod_stage_t;

    function automatic logic cmd_is_word(cmd_t cmd);
        return (cmd == CMD_MUL_WORD) || (cmd == CMD_IMUL_WORD);
    endfunction

    function automatic logic cmd_is_signed(cmd_t cmd);
        return (cmd == CMD_IMUL_BYTE) || (cmd == CMD_IMUL_WORD);
    endfunction

endpackage

// ===== src/imf_mult.sv =====
// ----------------------------------------------------------------------------
// imf_mult: operand extension and 17x17 signed multiply
// byte forms extend the low bytes, word forms the full words
// ----------------------------------------------------------------------------
module imf_mult
(
    input  imf_pkg::op_item_t    op,
    output imf_pkg::prod_stage_t prod
);

    logic               word;
    logic               sgn;
    logic signed [16:0] a_ext;
    logic signed [16:0] b_ext;
    logic signed [33:0] full;

    always_comb
    begin
        word = imf_pkg::cmd_is_word(op.cmd);
        sgn  = imf_pkg::cmd_is_signed(op.cmd);
        if (word)
        begin
            a_ext = {sgn & op.acc_value[15], op.acc_value};
            b_ext = {sgn & op.operand_value[15], op.operand_value};
        end
        else
        begin
            a_ext = {{9{sgn & op.acc_value[7]}}, op.acc_value[7:0]};
            b_ext = {{9{sgn & op.operand_value[7]}}, op.operand_value[7:0]};
        end
        full = a_ext * b_ext;

        prod.word     = word;
        prod.sgn      = sgn;
        prod.product  = full[31:0];
        prod.flags_in = op.flags_in;
    end

endmodule

// ===== src/imf_flags.sv =====
// ----------------------------------------------------------------------------
// imf_flags: result split and flag evaluation
// one add of high half plus carry-in gives all six arithmetic flags
// ----------------------------------------------------------------------------
module imf_flags
(
    input  imf_pkg::prod_stage_t prod,
    output imf_pkg::res_item_t   res
);

    logic [15:0] high;
    logic        cin;
    logic [15:0] sum_raw;
    logic [15:0] sum;
    logic        nonzero;
    logic [15:0] flags;

    always_comb
    begin
        if (prod.word)
        begin
            high = prod.product[31:16];
            cin  = prod.sgn & prod.product[15];
        end
        else
        begin
            high = {8'd0, prod.product[15:8]};
            cin  = prod.sgn & prod.product[7];
        end
        sum_raw = high + {15'd0, cin};
        // byte forms keep the low byte of the sum only
        sum     = prod.word ? sum_raw : {8'd0, sum_raw[7:0]};
        nonzero = |sum;

        flags                   = prod.flags_in;
        flags[imf_pkg::FLAG_CF] = nonzero;
        flags[imf_pkg::FLAG_OF] = nonzero;
        flags[imf_pkg::FLAG_ZF] = ~nonzero;
        flags[imf_pkg::FLAG_PF] = ~^sum[7:0];
        // carry-in only enters bit 0, so bit 4 of high^cin^sum is this
        flags[imf_pkg::FLAG_AF] = high[4] ^ sum[4];
        flags[imf_pkg::FLAG_SF] = prod.word ? sum[15] : sum[7];

        res.ax_out    = prod.word ? prod.product[15:0] : prod.product[15:0];
        res.dx_out    = prod.word ? prod.product[31:16] : 16'd0;
        res.dx_write  = prod.word;
        res.flags_out = flags;
    end

endmodule

// ===== src/mul_imul_with_flags.sv =====
// ----------------------------------------------------------------------------
// mul_imul_with_flags: 8086 multiply group with flag result
// path: an accepted operand transaction passes the product register, then the result register
// throughput: one transaction per cycle while res_stall is low, set by the two-stage pipeline
// (17x17 multiply into the product register, flag add into the result register)
// reset: rst_n clears both stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
module mul_imul_with_flags
(
    input  logic                clk,
    input  logic                rst_n,

    // operand channel
    input  logic                op_valid,
    output logic                op_stall,
    input  imf_pkg::op_item_t   op_data,

    // result channel
    output logic                res_valid,
    input  logic                res_stall,
    output imf_pkg::res_item_t  res_data
);

    // stage 1: product register
    logic                  prod_valid_reg;
    logic                  prod_valid_next;
    imf_pkg::prod_stage_t  prod_reg;
    imf_pkg::prod_stage_t  prod_next;

    // stage 2: result register, drives the result channel directly
    logic                  res_valid_reg;
    logic                  res_valid_next;
    imf_pkg::res_item_t    res_reg;
    imf_pkg::res_item_t    res_next;

    logic                  res_take;
    logic                  prod_take;
    logic                  op_take;

    imf_mult u_mult
    (
        .op   (op_data),
        .prod (prod_next)
    );

    imf_flags u_flags
    (
        .prod (prod_reg),
        .res  (res_next)
    );

    // each stage advances when the stage after it is empty or draining
    always_comb
    begin
        res_take  = ~res_valid_reg | ~res_stall;
        prod_take = ~prod_valid_reg | res_take;
        op_take   = op_valid & prod_take;

        // result register loads whatever the product stage holds when free
        res_valid_next  = res_take ? prod_valid_reg : res_valid_reg;
        prod_valid_next = prod_take ? op_valid : prod_valid_reg;
    end

    assign op_stall  = ~prod_take;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            prod_reg <= prod_next;
        end
        if (res_take && prod_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // a stall toward the operand side only when both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> (prod_valid_reg && res_valid_reg))
        else $error("operand stall with a free pipeline stage");

    // a new result appears only out of a filled product stage
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(prod_valid_reg))
        else $error("result valid without a product transaction");

    // byte forms never carry a high half
    a_dx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.dx_write || (res_reg.dx_out == 16'd0)))
        else $error("byte form with nonzero dx");

    // carry and overflow are one flag, and exclude zero
    a_cf_of: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |->
            ((res_reg.flags_out[imf_pkg::FLAG_CF] == res_reg.flags_out[imf_pkg::FLAG_OF])
            && !(res_reg.flags_out[imf_pkg::FLAG_CF] && res_reg.flags_out[imf_pkg::FLAG_ZF])))
        else $error("inconsistent carry, overflow and zero flags");

endmodule
